[hdl/lpmms_pkg.sv]
// ----------------------------------------------------------------------------
// lpmms_pkg: shared types and constants for the split-array largest-sum engine
// Holds the fixed field widths and the control state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmms_pkg;

  localparam int unsigned SEG_CFG_W = 11;  // max_segments register width
  localparam int unsigned SEG_CNT_W = 12;  // segment counter, holds limit + 1
  localparam int unsigned RESULT_W  = 26;  // min_largest_sum width

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

[hdl/linear_partition_min_max_sum.sv]
// Search: after the item marked last, about log2(total - max) + 1 probes each set up
//   a scan, then read the store one element at a time through the read port,
//   stopping early once the segment limit is passed; then the result is loaded.
// Input: no new array is taken until the result is in the output register.
// Reset: control state, counters and max_segments (to 1) clear at once; the
//   element store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// linear_partition_min_max_sum: split-array largest-sum engine
// Stores an array in a memory with one write and one read port, then binary-searches the smallest
// bound on segment sums with a greedy scan of the store for each probe.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_partition_min_max_sum #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration
  input  wire logic                                  cfg_wr_en,
  input  wire logic [lpmms_pkg::SEG_CFG_W-1:0]       cfg_wr_data,
  // input items
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [ELEMENT_BITS-1:0]               in_element,
  input  wire logic                                  in_last,
  // result items
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [lpmms_pkg::RESULT_W-1:0]             out_min_largest_sum,
  output logic                                       out_overflowed
);

  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned TOT_W  = ELEMENT_BITS + CNT_W;
  localparam int unsigned SCW    = lpmms_pkg::SEG_CNT_W;

  // element store
  logic [ELEMENT_BITS-1:0] mem [0:MAX_ELEMENTS-1];
  logic [ELEMENT_BITS-1:0] rd_data_r;
  logic                    wr_en;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;

  lpmms_pkg::state_t state_r, state_nxt;

  logic [lpmms_pkg::SEG_CFG_W-1:0] max_seg_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ELEMENT_BITS-1:0] max_r, max_nxt;
  logic [TOT_W-1:0]        tot_r, tot_nxt;
  logic                    ovf_r, ovf_nxt;

  logic [TOT_W-1:0]        low_r, low_nxt;
  logic [TOT_W-1:0]        high_r, high_nxt;
  logic [TOT_W-1:0]        mid_r, mid_nxt;
  logic [TOT_W-1:0]        cur_r, cur_nxt;
  logic [SCW-1:0]          segs_r, segs_nxt;
  logic [CNT_W-1:0]        iss_r, iss_nxt;
  logic                    rv_r, rv_nxt;
  logic                    rl_r, rl_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [lpmms_pkg::RESULT_W-1:0] out_sum_r, out_sum_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic                    in_fire;
  logic                    store_full;
  logic [SCW-1:0]          limit;
  logic [TOT_W:0]          cur_sum;
  logic                    over_bound;
  logic [SCW-1:0]          segs_inc;
  logic                    seg_fail;

  assign in_ready   = (state_r == lpmms_pkg::ST_LOAD);
  assign in_fire    = in_valid && in_ready;
  assign store_full = (cnt_r >= CNT_W'(MAX_ELEMENTS));
  assign wr_en      = in_fire && !store_full;

  assign limit      = (max_seg_r == '0) ? SCW'(1) : SCW'(max_seg_r);
  assign cur_sum    = {1'b0, cur_r} + (TOT_W + 1)'(rd_data_r);
  assign over_bound = (cur_sum > {1'b0, mid_r});
  assign segs_inc   = segs_r + SCW'(1);
  assign seg_fail   = over_bound && (segs_inc > limit);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    tot_nxt       = tot_r;
    ovf_nxt       = ovf_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    cur_nxt       = cur_r;
    segs_nxt      = segs_r;
    iss_nxt       = iss_r;
    rv_nxt        = rv_r;
    rl_nxt        = rl_r;
    rd_en         = 1'b0;
    rd_addr       = iss_r[ADDR_W-1:0];
    out_valid_nxt = out_valid_r && !out_ready;
    out_sum_nxt   = out_sum_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      lpmms_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (!store_full) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            if (in_element > max_r) begin
              max_nxt = in_element;
            end
            tot_nxt = tot_r + TOT_W'(in_element);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            low_nxt   = TOT_W'(max_nxt);
            high_nxt  = tot_nxt;
            state_nxt = lpmms_pkg::ST_PROBE;
          end
        end
      end

      lpmms_pkg::ST_PROBE: begin
        // set up one greedy scan at the midpoint, or finish
        rv_nxt   = 1'b0;
        iss_nxt  = '0;
        cur_nxt  = '0;
        segs_nxt = SCW'(1);
        mid_nxt  = low_r + ((high_r - low_r) >> 1);
        if (low_r < high_r) begin
          state_nxt = lpmms_pkg::ST_SCAN;
        end else begin
          state_nxt = lpmms_pkg::ST_EMIT;
        end
      end

      lpmms_pkg::ST_SCAN: begin
        // issue the next read
        if (iss_r < cnt_r) begin
          rd_en   = 1'b1;
          iss_nxt = iss_r + CNT_W'(1);
          rv_nxt  = 1'b1;
          rl_nxt  = ((iss_r + CNT_W'(1)) == cnt_r);
        end else begin
          rv_nxt  = 1'b0;
        end
        // consume the element read last cycle
        if (rv_r) begin
          if (over_bound) begin
            segs_nxt = segs_inc;
            cur_nxt  = TOT_W'(rd_data_r);
          end else begin
            cur_nxt  = cur_sum[TOT_W-1:0];
          end
          if (seg_fail) begin
            low_nxt   = mid_r + TOT_W'(1);
            state_nxt = lpmms_pkg::ST_PROBE;
          end else if (rl_r) begin
            high_nxt  = mid_r;
            state_nxt = lpmms_pkg::ST_PROBE;
          end
        end
      end

      lpmms_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = lpmms_pkg::RESULT_W'(low_r);
          out_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          max_nxt       = '0;
          tot_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = lpmms_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = lpmms_pkg::ST_LOAD;
      end
    endcase
  end

  // element store: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_element;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpmms_pkg::ST_LOAD;
      max_seg_r   <= lpmms_pkg::SEG_CFG_W'(1);
      cnt_r       <= '0;
      max_r       <= '0;
      tot_r       <= '0;
      ovf_r       <= 1'b0;
      rv_r        <= 1'b0;
      rl_r        <= 1'b0;
      iss_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        max_seg_r <= cfg_wr_data;
      end
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      tot_r       <= tot_nxt;
      ovf_r       <= ovf_nxt;
      rv_r        <= rv_nxt;
      rl_r        <= rl_nxt;
      iss_r       <= iss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r     <= low_nxt;
    high_r    <= high_nxt;
    mid_r     <= mid_nxt;
    cur_r     <= cur_nxt;
    segs_r    <= segs_nxt;
    out_sum_r <= out_sum_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_min_largest_sum = out_sum_r;
  assign out_overflowed      = out_ovf_r;

endmodule

`default_nettype wire
